// ===== src/dbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared constants and types of the depth background subtraction block.
// ----------------------------------------------------------------------------
package dbs_pkg;

   localparam int MAX_WIDTH  = 640;
   localparam int MAX_HEIGHT = 480;
   localparam int KERNEL     = 8;
   localparam int ANCHOR     = KERNEL / 2;
   localparam int LAG        = KERNEL - 1 - ANCHOR;
   localparam int MIN_GEOM   = 8;

   localparam int DEPTH_W = 16;
   localparam int COL_W   = 10;
   localparam int ROW_W   = 9;
   localparam int CNT_W   = 16;
   localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int RUN_W   = $clog2(KERNEL + 1);
   localparam int LAG_W   = $clog2(LAG * MAX_WIDTH + LAG + 1);
   localparam int FIFO_AW = LAG_W;

   localparam int BG_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int FIFO_DEPTH = 1 << FIFO_AW;

   localparam logic [CNT_W-1:0]   RST_LEARN_FRAMES = 16'd100;
   localparam logic [DEPTH_W-1:0] RST_THRESHOLD    = 16'd150;
   localparam logic [COL_W-1:0]   RST_WIDTH        = 10'd640;
   localparam logic [ROW_W-1:0]   RST_HEIGHT       = 9'd480;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      CSR_LEARN_FRAMES,
      CSR_THRESHOLD,
      CSR_WIDTH,
      CSR_HEIGHT
   } csr_idx_type;

   typedef struct packed {
      logic [RUN_W-1:0] run;
      logic [COL_W-1:0] col;
   } tap_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [RUN_W-1:0] needed;
   } win_type;

endpackage

// ===== src/dbs_ram.sv =====
// ----------------------------------------------------------------------------
// dbs_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/dbs_cell.sv =====
// ----------------------------------------------------------------------------
// dbs_cell
// One column tap of the erosion window: holds a vertical run length.
// ----------------------------------------------------------------------------
module dbs_cell import dbs_pkg::*; (
   input  logic    clock,
   input  logic    shift_en,
   input  tap_type tap_i,
   input  win_type win_i,
   output tap_type tap_o,
   output logic    ok_o
);

   tap_type tap_ff;
   logic    in_win;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         tap_ff <= tap_i;
      end
   end

   always_comb begin
      in_win = (({1'b0, tap_ff.col} + (COL_W+1)'(ANCHOR)) >= {1'b0, win_i.col}) &&
               ({1'b0, tap_ff.col} <= ({1'b0, win_i.col} + (COL_W+1)'(LAG)));
      ok_o   = !in_win || (tap_ff.run >= win_i.needed);
   end

   assign tap_o = tap_ff;

endmodule

// ===== src/depth_background_subtract_top.sv =====
// ----------------------------------------------------------------------------
// depth_background_subtract_top
// Depth background subtraction with 8x8 mask erosion over a pixel stream.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while req_tready is high. After reset
// a clearing pass marks the background store as zero depth, valid;
// req_tready stays low meanwhile. Learning results pass the stage-one
// and response registers; in detection frames results lag by three rows
// plus three pixels and drain transactions flush the rest of the frame.
// Erosion runs as per-column vertical run counters kept in a line RAM,
// followed by a chain of eight tap cells that slides across the row.
module depth_background_subtract_top import dbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // depth_mm, depth_valid
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_depth_mm, out_valid, pixel_col, pixel_row
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // learning
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic [CNT_W-1:0]   learn_frames_ff;
   logic [DEPTH_W-1:0] thr_ff;
   logic [COL_W-1:0]   width_ff;
   logic [ROW_W-1:0]   height_ff;

   logic               clr_busy_ff;
   logic [POS_W-1:0]   clr_addr_ff;

   logic [COL_W-1:0]   cur_w_ff, cur_w_in;
   logic [ROW_W-1:0]   cur_h_ff, cur_h_in;
   logic               cur_learn_ff, cur_learn_in;
   logic               cur_first_ff, cur_first_in;
   logic [LAG_W-1:0]   lag_ff, lag_in;
   logic [CNT_W-1:0]   learned_ff, learned_in;

   logic [POS_W-1:0]   in_pos_ff, in_pos_in;
   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic               in_done_ff, in_done_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [FIFO_AW-1:0] out_ptr_ff, out_ptr_in;

   logic               s1_v_ff, s1_v_in;
   logic               s1_learn_ff, s1_learn_in;
   logic               s1_dv_ff, s1_dv_in;
   logic [DEPTH_W-1:0] s1_d_ff, s1_d_in;
   logic [COL_W-1:0]   s1_col_ff, s1_col_in;
   logic [ROW_W-1:0]   s1_row_ff, s1_row_in;
   logic               s1_end_ff, s1_end_in;
   logic [RUN_W-1:0]   s1_need_ff, s1_need_in;

   logic               rsp_v_ff;
   logic [DEPTH_W-1:0] rsp_d_ff;
   logic               rsp_dv_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic               rsp_end_ff;
   logic               rsp_learn_ff;

   logic               acc, pix, start, s1_move;
   logic [COL_W-1:0]   clamp_w, eff_w;
   logic [ROW_W-1:0]   clamp_h, eff_h;
   logic               eff_learn, eff_first;
   logic [LAG_W-1:0]   eff_lag;
   logic               in_last_col, in_last, out_last_col, out_last, emit_norm;

   logic [DEPTH_W:0]   bg_rdata, bg_wdata;
   logic               bg_we, bg_v;
   logic [POS_W-1:0]   bg_waddr;
   logic [DEPTH_W-1:0] bg_d, d_sub, diff;
   logic               dv, v_sub, mask;

   logic [RUN_W-1:0]   run_rdata, run_old, run_new;
   logic               run_we;
   logic [DEPTH_W:0]   fifo_rdata;
   logic               fifo_we;

   logic               shift_en, emit, finish;
   tap_type            tap_feed;
   tap_type            tap_chain [KERNEL];
   win_type            win;
   logic [KERNEL-1:0]  ok_vec;
   logic               m_eff;
   logic [ROW_W:0]     row_top, row_bot, row_lim;

   // ------------------------------------------------------------------------
   always_comb begin
      clamp_w = (width_ff < COL_W'(MIN_GEOM)) ? COL_W'(MIN_GEOM) :
                (width_ff > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : width_ff;
      clamp_h = (height_ff < ROW_W'(MIN_GEOM)) ? ROW_W'(MIN_GEOM) :
                (height_ff > ROW_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : height_ff;
   end

   assign s1_move    = !rsp_v_ff || rsp_tready;
   assign req_tready = !clr_busy_ff && (!s1_v_ff || s1_move);
   assign acc        = req_tvalid && req_tready;
   assign pix        = (req_tuser == REQ_PIXEL);
   assign start      = pix && !in_done_ff && (in_pos_ff == '0);

   always_comb begin
      eff_w     = start ? clamp_w : cur_w_ff;
      eff_h     = start ? clamp_h : cur_h_ff;
      eff_learn = start ? (learned_ff < learn_frames_ff) : cur_learn_ff;
      eff_first = start ? (learned_ff == '0) : cur_first_ff;
      eff_lag   = start ? (LAG_W'(clamp_w) * LAG_W'(LAG) + LAG_W'(LAG)) : lag_ff;
   end

   assign in_last_col  = (in_col_ff == eff_w - 1'b1);
   assign in_last      = in_last_col && (in_row_ff == eff_h - 1'b1);
   assign out_last_col = (out_col_ff == cur_w_ff - 1'b1);
   assign out_last     = out_last_col && (out_row_ff == cur_h_ff - 1'b1);
   assign emit_norm    = (in_pos_ff >= POS_W'(eff_lag));

   // Pixel path: substitute, compare against background, update run length.
   always_comb begin
      dv      = req_tdata[DEPTH_W];
      bg_v    = bg_rdata[DEPTH_W];
      bg_d    = bg_rdata[DEPTH_W-1:0];
      d_sub   = dv ? req_tdata[DEPTH_W-1:0] : bg_d;
      v_sub   = dv || bg_v;
      diff    = (d_sub > bg_d) ? (d_sub - bg_d) : (bg_d - d_sub);
      mask    = !bg_v || (diff >= thr_ff);
      run_old = (in_row_ff == '0) ? '0 : run_rdata;
      run_new = !mask ? '0 :
                (run_old == RUN_W'(KERNEL)) ? RUN_W'(KERNEL) : run_old + 1'b1;
   end

   // Rows of the erosion window that lie inside the frame.
   always_comb begin
      row_top = (out_row_ff < ROW_W'(ANCHOR)) ? '0 :
                {1'b0, out_row_ff} - (ROW_W+1)'(ANCHOR);
      row_lim = {1'b0, cur_h_ff} - 1'b1;
      row_bot = (({1'b0, out_row_ff} + (ROW_W+1)'(LAG)) > row_lim) ? row_lim :
                {1'b0, out_row_ff} + (ROW_W+1)'(LAG);
   end

   // ------------------------------------------------------------------------
   always_comb begin
      cur_w_in     = cur_w_ff;
      cur_h_in     = cur_h_ff;
      cur_learn_in = cur_learn_ff;
      cur_first_in = cur_first_ff;
      lag_in       = lag_ff;
      learned_in   = learned_ff;
      in_pos_in    = in_pos_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_done_in   = in_done_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_ptr_in   = out_ptr_ff;
      bg_we        = 1'b0;
      run_we       = 1'b0;
      fifo_we      = 1'b0;
      shift_en     = 1'b0;
      emit         = 1'b0;
      finish       = 1'b0;
      tap_feed.run = run_new;
      tap_feed.col = in_col_ff;
      s1_learn_in  = 1'b0;
      s1_dv_in     = fifo_rdata[DEPTH_W];
      s1_d_in      = fifo_rdata[DEPTH_W-1:0];
      s1_col_in    = out_col_ff;
      s1_row_in    = out_row_ff;
      s1_end_in    = out_last;
      s1_need_in   = RUN_W'(row_bot - row_top + 1'b1);

      if (acc) begin
         if (in_done_ff) begin
            shift_en     = 1'b1;
            tap_feed.run = run_rdata;
            in_col_in    = in_last_col ? '0 : in_col_ff + 1'b1;
            emit         = 1'b1;
         end else if (pix) begin
            if (start) begin
               cur_w_in     = eff_w;
               cur_h_in     = eff_h;
               cur_learn_in = eff_learn;
               cur_first_in = eff_first;
               lag_in       = eff_lag;
            end
            in_pos_in = in_pos_ff + 1'b1;
            in_col_in = in_last_col ? '0 : in_col_ff + 1'b1;
            in_row_in = (in_last_col && !in_last) ? in_row_ff + 1'b1 : in_row_ff;
            if (eff_learn) begin
               bg_we       = eff_first || dv;
               s1_learn_in = 1'b1;
               s1_dv_in    = 1'b1;
               s1_d_in     = '0;
               s1_col_in   = in_col_ff;
               s1_row_in   = in_row_ff;
               s1_end_in   = in_last;
               finish      = in_last;
            end else begin
               run_we     = 1'b1;
               fifo_we    = 1'b1;
               shift_en   = 1'b1;
               in_done_in = in_last;
               emit       = emit_norm;
            end
         end
      end

      if (emit && !s1_learn_in) begin
         out_ptr_in = out_ptr_ff + 1'b1;
         out_col_in = out_last_col ? '0 : out_col_ff + 1'b1;
         out_row_in = out_last_col ? out_row_ff + 1'b1 : out_row_ff;
         finish     = out_last;
      end

      if (finish) begin
         in_pos_in  = '0;
         in_col_in  = '0;
         in_row_in  = '0;
         in_done_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
         out_ptr_in = '0;
         learned_in = (learned_ff == '1) ? learned_ff : learned_ff + 1'b1;
      end

      s1_v_in = (emit || s1_learn_in) ? 1'b1 : (s1_move ? 1'b0 : s1_v_ff);
   end

   assign bg_waddr = clr_busy_ff ? clr_addr_ff : in_pos_ff;
   assign bg_wdata = clr_busy_ff ? {1'b1, DEPTH_W'(0)} : {dv, req_tdata[DEPTH_W-1:0]};

   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         learn_frames_ff <= RST_LEARN_FRAMES;
         thr_ff          <= RST_THRESHOLD;
         width_ff        <= RST_WIDTH;
         height_ff       <= RST_HEIGHT;
         clr_busy_ff     <= 1'b1;
         clr_addr_ff     <= '0;
         cur_w_ff        <= RST_WIDTH;
         cur_h_ff        <= RST_HEIGHT;
         cur_learn_ff    <= 1'b1;
         cur_first_ff    <= 1'b1;
         lag_ff          <= LAG_W'(LAG * MAX_WIDTH + LAG);
         learned_ff      <= '0;
         in_pos_ff       <= '0;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         in_done_ff      <= 1'b0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         out_ptr_ff      <= '0;
         s1_v_ff         <= 1'b0;
         rsp_v_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx_type'(csr_addr))
               CSR_LEARN_FRAMES: learn_frames_ff <= csr_wdata;
               CSR_THRESHOLD:    thr_ff          <= csr_wdata;
               CSR_WIDTH:        width_ff        <= csr_wdata[COL_W-1:0];
               CSR_HEIGHT:       height_ff       <= csr_wdata[ROW_W-1:0];
            endcase
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == POS_W'(BG_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         cur_w_ff     <= cur_w_in;
         cur_h_ff     <= cur_h_in;
         cur_learn_ff <= cur_learn_in;
         cur_first_ff <= cur_first_in;
         lag_ff       <= lag_in;
         learned_ff   <= learned_in;
         in_pos_ff    <= in_pos_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_done_ff   <= in_done_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_ptr_ff   <= out_ptr_in;
         s1_v_ff      <= s1_v_in;
         if (s1_move) begin
            rsp_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit || s1_learn_in) begin
         s1_learn_ff <= s1_learn_in;
         s1_dv_ff    <= s1_dv_in;
         s1_d_ff     <= s1_d_in;
         s1_col_ff   <= s1_col_in;
         s1_row_ff   <= s1_row_in;
         s1_end_ff   <= s1_end_in;
         s1_need_ff  <= s1_need_in;
      end
      if (s1_move && s1_v_ff) begin
         rsp_d_ff     <= (s1_dv_ff && m_eff) ? s1_d_ff : '0;
         rsp_dv_ff    <= s1_dv_ff;
         rsp_col_ff   <= s1_col_ff;
         rsp_row_ff   <= s1_row_ff;
         rsp_end_ff   <= s1_end_ff;
         rsp_learn_ff <= s1_learn_ff;
      end
   end

   // ------------------------------------------------------------------------
   dbs_ram #(.WIDTH(DEPTH_W + 1), .DEPTH(BG_DEPTH)) u_bg_ram (
      .clock (clock),
      .we    (bg_we || clr_busy_ff),
      .waddr (bg_waddr),
      .wdata (bg_wdata),
      .raddr (in_pos_in),
      .rdata (bg_rdata)
   );

   dbs_ram #(.WIDTH(RUN_W), .DEPTH(MAX_WIDTH)) u_run_ram (
      .clock (clock),
      .we    (run_we),
      .waddr (in_col_ff),
      .wdata (run_new),
      .raddr (in_col_in),
      .rdata (run_rdata)
   );

   dbs_ram #(.WIDTH(DEPTH_W + 1), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
      .clock (clock),
      .we    (fifo_we),
      .waddr (in_pos_ff[FIFO_AW-1:0]),
      .wdata ({v_sub, d_sub}),
      .raddr (out_ptr_in),
      .rdata (fifo_rdata)
   );

   assign win.col    = s1_col_ff;
   assign win.needed = s1_need_ff;

   for (genvar k = 0; k < KERNEL; k++) begin : g_tap
      dbs_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .tap_i    ((k == 0) ? tap_feed : tap_chain[(k == 0) ? 0 : k - 1]),
         .win_i    (win),
         .tap_o    (tap_chain[k]),
         .ok_o     (ok_vec[k])
      );
   end

   assign m_eff = s1_learn_ff || (&ok_vec);

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {4'd0, rsp_row_ff, rsp_col_ff, rsp_dv_ff, rsp_d_ff};
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tuser  = rsp_learn_ff;

   // ------------------------------------------------------------------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("transaction accepted during background clear");

   a_learned_monotone: assert property (@(posedge clock) disable iff (reset)
      !reset |=> learned_ff >= $past(learned_ff))
      else $error("learned frame count went backwards");

   a_done_on_last_row: assert property (@(posedge clock) disable iff (reset)
      in_done_ff |-> in_row_ff == cur_h_ff - 1'b1)
      else $error("input marked done away from last row");

   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_move |-> !shift_en)
      else $error("tap chain shifted under a pending result");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for depth_background_subtract_top: streams frames of
// depth pixels and drain transactions, predicts every result transaction
// (learning, substitution, threshold mask, 8x8 erosion, drain) and compares
// each one against the oldest prediction, under random sender gaps and
// receiver stalls, across several register settings.
// ----------------------------------------------------------------------------
module tb_top import dbs_pkg::*; ();

   localparam int RING      = KERNEL + 1;
   localparam int IDLE_MAX  = 1000000;
   localparam int SETTLE    = 40;

   typedef struct {
      logic [15:0] depth;
      logic        valid;
      logic [9:0]  col;
      logic [8:0]  row;
      logic        last;
      logic        learn;
   } pix_result_type;

   class bg_scoreboard_type;
      logic [16:0]    bg_mem [BG_DEPTH];
      logic           mask_ring [RING * MAX_WIDTH];
      logic [16:0]    delay_ring [RING * MAX_WIDTH];
      int unsigned    frames_learned;
      int unsigned    in_pos, out_pos;
      int unsigned    learn_frames, threshold, width_reg, height_reg;
      int unsigned    cur_w, cur_h;
      bit             cur_learn, cur_first;
      pix_result_type pending[$];
      int             errors;
      int             checked;

      function new();
         for (int i = 0; i < BG_DEPTH; i++) bg_mem[i] = 17'h10000;
         frames_learned = 0;
         in_pos = 0;
         out_pos = 0;
         learn_frames = RST_LEARN_FRAMES;
         threshold = RST_THRESHOLD;
         width_reg = RST_WIDTH;
         height_reg = RST_HEIGHT;
         errors = 0;
         checked = 0;
         latch();
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void latch();
         cur_w = clamp(width_reg, MIN_GEOM, MAX_WIDTH);
         cur_h = clamp(height_reg, MIN_GEOM, MAX_HEIGHT);
         cur_learn = frames_learned < learn_frames;
         cur_first = frames_learned == 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [15:0] val);
         case (idx)
            CSR_LEARN_FRAMES: learn_frames = val;
            CSR_THRESHOLD:    threshold = val;
            CSR_WIDTH:        width_reg = val[COL_W-1:0];
            CSR_HEIGHT:       height_reg = val[ROW_W-1:0];
         endcase
      endfunction

      function void frame_done();
         in_pos = 0;
         out_pos = 0;
         if (frames_learned < 16'hFFFF) frames_learned++;
      endfunction

      function void push(logic [15:0] d, logic v, int unsigned c, int unsigned r,
                         logic e, logic l);
         pix_result_type x;
         x.depth = d;
         x.valid = v;
         x.col = 10'(c);
         x.row = 9'(r);
         x.last = e;
         x.learn = l;
         pending.push_back(x);
      endfunction

      function void emit_eroded();
         int unsigned n, pos;
         int r, c, rr, cc;
         logic m;
         logic [16:0] d;
         n = cur_w * cur_h;
         pos = out_pos;
         r = pos / cur_w;
         c = pos % cur_w;
         m = 1'b1;
         for (int dr = -ANCHOR; dr < KERNEL - ANCHOR; dr++)
            for (int dc = -ANCHOR; dc < KERNEL - ANCHOR; dc++) begin
               rr = r + dr;
               cc = c + dc;
               if (rr >= 0 && rr < int'(cur_h) && cc >= 0 && cc < int'(cur_w))
                  m &= mask_ring[(rr % RING) * MAX_WIDTH + cc];
            end
         d = delay_ring[(r % RING) * MAX_WIDTH + c];
         push((d[16] && m) ? d[15:0] : 16'd0, d[16], c, r, pos == n - 1, 1'b0);
         out_pos++;
         if (pos == n - 1) frame_done();
      endfunction

      function void note_input(logic kind, logic [15:0] depth, logic dv);
         int unsigned n, pos, r, c, slot, diff;
         logic [16:0] bg;
         logic [15:0] d;
         logic val;
         if (kind == REQ_PIXEL && in_pos == 0 && out_pos == 0) latch();
         n = cur_w * cur_h;
         if (kind == REQ_DRAIN || in_pos >= n) begin
            if (in_pos >= n && out_pos < n) emit_eroded();
            return;
         end
         pos = in_pos;
         r = pos / cur_w;
         c = pos % cur_w;
         bg = bg_mem[pos];
         if (cur_learn) begin
            if (cur_first || dv) bg_mem[pos] = {dv, depth};
            push(16'd0, 1'b1, c, r, pos == n - 1, 1'b1);
            in_pos++;
            out_pos++;
            if (pos == n - 1) frame_done();
         end else begin
            d = dv ? depth : bg[15:0];
            val = dv ? 1'b1 : bg[16];
            diff = d > bg[15:0] ? d - bg[15:0] : bg[15:0] - d;
            slot = (r % RING) * MAX_WIDTH + c;
            mask_ring[slot] = !bg[16] || diff >= threshold;
            delay_ring[slot] = {val, d};
            in_pos++;
            if (in_pos - out_pos > LAG * cur_w + LAG) emit_eroded();
         end
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      endtask

      task check_result(logic [15:0] d, logic v, logic [9:0] c, logic [8:0] r,
                        logic e, logic l);
         pix_result_type x;
         if (pending.size() == 0) begin
            report("unexpected result transaction, col", c, -1);
            return;
         end
         x = pending.pop_front();
         checked++;
         if (d !== x.depth) report("out_depth_mm", d, x.depth);
         if (v !== x.valid) report("out_valid", v, x.valid);
         if (c !== x.col)   report("pixel_col", c, x.col);
         if (r !== x.row)   report("pixel_row", r, x.row);
         if (e !== x.last)  report("frame_end", e, x.last);
         if (l !== x.learn) report("learning", l, x.learn);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // depth_mm, depth_valid
   logic        req_tuser;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // out_depth_mm, out_valid, pixel_col, pixel_row
   logic        rsp_tlast;
   logic        rsp_tuser;   // learning
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   bg_scoreboard_type sb = new();
   int idle_cycles = 0;
   int sent = 0;
   int frames_sent = 0;
   int burst_left = 0;
   int gap_pct = 20;
   bit long_stall_done = 0;
   int stall_left = 0;
   int stall_pct = 0;

   depth_background_subtract_top dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[26:17],
                         rsp_tdata[35:27], rsp_tlast, rsp_tuser);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("timeout: no transaction for %0d cycles", IDLE_MAX);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: shifting stall density, one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!long_stall_done && sent >= 300) begin
            long_stall_done = 1;
            stall_left = 3000;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 199) == 0)
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  default: stall_pct = 75;
               endcase
            rsp_tready <= $urandom_range(0, 99) >= stall_pct;
         end
      end
   end

   task send(logic kind, logic [15:0] depth, logic dv);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, dv, depth};
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, depth, dv);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 9) == 0) gap_pct = $urandom_range(0, 2) * 30;
         gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_csr(csr_idx_type idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   // one full frame plus its drain; fr0..fr1, fc0..fc1 mark a foreground rectangle
   task run_frame(bit directed);
      int w, h, fr0, fc0, fr1, fc1, pos;
      logic [15:0] d;
      logic dv;
      w = sb.clamp(sb.width_reg, MIN_GEOM, MAX_WIDTH);
      h = sb.clamp(sb.height_reg, MIN_GEOM, MAX_HEIGHT);
      fr0 = $urandom_range(0, h - 1);
      fc0 = $urandom_range(0, w - 1);
      fr1 = fr0 + $urandom_range(0, 14);
      fc1 = fc0 + $urandom_range(0, 14);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            pos = r * w + c;
            d = 16'd1000 + 16'((pos * 37) % 500) + 16'($urandom_range(0, 40)) - 16'd20;
            if (r >= fr0 && r <= fr1 && c >= fc0 && c <= fc1) d = d - 16'd600;
            dv = $urandom_range(0, 99) >= 6;
            case ($urandom_range(0, 99))
               0: d = 16'd0;
               1: d = 16'hFFFF;
               2, 3: d = 16'($urandom);
               default: ;
            endcase
            if (directed && pos < 4) begin
               d = pos[0] ? 16'hFFFF : 16'd0;
               dv = pos[1];
            end
            if ($urandom_range(0, 99) < 3) send(REQ_DRAIN, 16'($urandom), 1'($urandom));
            send(REQ_PIXEL, d, dv);
         end
      while (sb.in_pos != 0 || sb.out_pos != 0) begin
         if ($urandom_range(0, 99) < 15) send(REQ_PIXEL, 16'($urandom), 1'($urandom));
         else send(REQ_DRAIN, 16'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 3) == 0) send(REQ_DRAIN, 16'($urandom), 1'($urandom));
      frames_sent++;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_PIXEL;
      csr_we = 1'b0;
      csr_addr = CSR_LEARN_FRAMES;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_LEARN_FRAMES, 16'd2);
      write_csr(CSR_THRESHOLD, 16'd150);
      write_csr(CSR_WIDTH, 16'd0);
      write_csr(CSR_HEIGHT, 16'd8);
      run_frame(1);
      run_frame(1);
      run_frame(1);
      wait_idle();

      while (sent < 1000) begin
         case ($urandom_range(0, 9))
            0: write_csr(CSR_THRESHOLD, 16'd0);
            1: write_csr(CSR_THRESHOLD, 16'hFFFF);
            2, 3: write_csr(CSR_THRESHOLD, 16'($urandom_range(0, 65535)));
            default: write_csr(CSR_THRESHOLD, 16'($urandom_range(0, 1500)));
         endcase
         case ($urandom_range(0, 7))
            0: write_csr(CSR_WIDTH, 16'd0);
            1: write_csr(CSR_WIDTH, 16'd8);
            default: write_csr(CSR_WIDTH, 16'($urandom_range(8, 20)));
         endcase
         case ($urandom_range(0, 7))
            0: write_csr(CSR_HEIGHT, 16'd3);
            1: write_csr(CSR_HEIGHT, 16'd8);
            default: write_csr(CSR_HEIGHT, 16'($urandom_range(8, 14)));
         endcase
         case ($urandom_range(0, 9))
            0: write_csr(CSR_LEARN_FRAMES, 16'(sb.frames_learned + 1));
            1: write_csr(CSR_LEARN_FRAMES, 16'hFFFF);
            2: write_csr(CSR_LEARN_FRAMES, 16'd0);
            default: ;
         endcase
         run_frame(0);
         wait_idle();
         if (sb.learn_frames == 16'hFFFF) begin
            run_frame(0);
            wait_idle();
            write_csr(CSR_LEARN_FRAMES, 16'd0);
         end
      end

      write_csr(CSR_LEARN_FRAMES, 16'd0);
      write_csr(CSR_WIDTH, 16'd12);
      write_csr(CSR_HEIGHT, 16'd0);
      run_frame(0);
      wait_idle();
      write_csr(CSR_WIDTH, 16'd0);
      write_csr(CSR_HEIGHT, 16'd20);
      write_csr(CSR_THRESHOLD, 16'd100);
      run_frame(0);
      wait_idle();
      write_csr(CSR_WIDTH, 16'd9);
      write_csr(CSR_HEIGHT, 16'd16);
      run_frame(0);
      wait_idle();

      $display("covered %0d frames, %0d input transactions, %0d results checked",
               frames_sent, sent, sb.checked);
      $display("small geometries with clamped register values, learning and detection");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
